// File: design/ers_pkg.sv
`default_nettype none
package ers_pkg;

   localparam int LENGTH_W   = 6;
   localparam int HITS_W     = 6;
   localparam int ROT_W      = 5;
   localparam int POS_W      = 5;
   localparam int USED_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [LENGTH_W-1:0] LENGTH_RST = 6'd32;
   localparam logic [HITS_W-1:0]   HITS_RST   = 6'd16;
   localparam logic [ROT_W-1:0]    ROT_RST    = 5'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LENGTH   = 2'd0,
      CSR_HITS     = 2'd1,
      CSR_ROTATION = 2'd2,
      CSR_INVERT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] pattern_length;
      logic [HITS_W-1:0]   hit_count;
      logic [ROT_W-1:0]    rotation;
      logic                invert_pattern;
   } cfg_type;

   // clamp the programmed length to 1..max_steps
   function automatic logic [USED_W-1:0] used_length(logic [LENGTH_W-1:0] len,
                                                     int max_steps);
      logic [USED_W-1:0] n;
      if (len == '0) begin
         n = USED_W'(1);
      end else if (int'(len) > max_steps) begin
         n = USED_W'(max_steps);
      end else begin
         n = USED_W'(len);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// File: design/ers_gen.sv
`default_nettype none
module ers_gen #(
   parameter int MAX_STEPS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ers_pkg::cfg_type       cfg,
   input  wire logic                   start,
   output logic                        done,
   output logic [MAX_STEPS-1:0]        pattern
);
   import ers_pkg::*;

   localparam int LEN_W = $clog2(MAX_STEPS + 1);
   localparam int IDX_W = $clog2(MAX_STEPS);

   typedef enum logic [6:0] {
      GS_IDLE   = 7'b0000001,
      GS_MOD    = 7'b0000010,
      GS_DECIDE = 7'b0000100,
      GS_COPY   = 7'b0001000,
      GS_REPEAT = 7'b0010000,
      GS_ROTATE = 7'b0100000,
      GS_FINISH = 7'b1000000
   } gen_state_type;

   gen_state_type        state_ff, state_in;
   logic [ROT_W-1:0]     s_ff, s_in;
   logic [MAX_STEPS-1:0] lp_ff, lp_in, rp_ff, rp_in, remp_ff, remp_in;
   logic [MAX_STEPS-1:0] rot_ff, rot_in, pattern_ff, pattern_in;
   logic [LEN_W-1:0]     lb_ff, lb_in, rb_ff, rb_in, ll_ff, ll_in, rl_ff, rl_in;
   logic [LEN_W-1:0]     remb_ff, remb_in, reml_ff, reml_in;
   logic [LEN_W-1:0]     i_ff, i_in, p_ff, p_in;
   logic [IDX_W-1:0]     j_ff, j_in;

   logic [LEN_W-1:0]     n;
   logic [LEN_W-1:0]     k;
   logic [MAX_STEPS-1:0] mask;

   always_comb begin
      n = LEN_W'(used_length(cfg.pattern_length, MAX_STEPS));
      if (int'(cfg.hit_count) > int'(n)) begin
         k = n;
      end else begin
         k = LEN_W'(cfg.hit_count);
      end
      for (int b = 0; b < MAX_STEPS; b++) begin
         mask[b] = (b < int'(n));
      end
   end

   always_comb begin
      state_in   = state_ff;
      s_in       = s_ff;
      lp_in      = lp_ff;
      rp_in      = rp_ff;
      remp_in    = remp_ff;
      rot_in     = rot_ff;
      pattern_in = pattern_ff;
      lb_in      = lb_ff;
      rb_in      = rb_ff;
      ll_in      = ll_ff;
      rl_in      = rl_ff;
      remb_in    = remb_ff;
      reml_in    = reml_ff;
      i_in       = i_ff;
      p_in       = p_ff;
      j_in       = j_ff;
      unique case (state_ff)
         GS_IDLE: begin
            if (start) begin
               s_in     = cfg.rotation;
               state_in = GS_MOD;
            end
         end
         GS_MOD: begin
            if (int'(s_ff) >= int'(n)) begin
               s_in = s_ff - ROT_W'(n);
            end else if (k == '0 || k >= n) begin
               lp_in    = (k == '0) ? '0 : mask;
               i_in     = '0;
               j_in     = IDX_W'(s_ff);
               rot_in   = '0;
               state_in = GS_ROTATE;
            end else begin
               lp_in    = MAX_STEPS'(1);
               rp_in    = '0;
               lb_in    = k;
               ll_in    = LEN_W'(1);
               rb_in    = n - k;
               rl_in    = LEN_W'(1);
               state_in = GS_DECIDE;
            end
         end
         GS_DECIDE: begin
            if (rb_ff == '0) begin
               p_in     = ll_ff;
               i_in     = '0;
               state_in = GS_REPEAT;
            end else begin
               if (lb_ff > rb_ff) begin
                  remb_in = lb_ff - rb_ff;
                  remp_in = lp_ff;
                  reml_in = ll_ff;
                  lb_in   = rb_ff;
               end else begin
                  remb_in = rb_ff - lb_ff;
                  remp_in = rp_ff;
                  reml_in = rl_ff;
               end
               i_in     = '0;
               state_in = GS_COPY;
            end
         end
         GS_COPY: begin
            if (i_ff == rl_ff) begin
               rb_in    = remb_ff;
               rp_in    = remp_ff;
               rl_in    = reml_ff;
               state_in = GS_DECIDE;
            end else begin
               lp_in[ll_ff[IDX_W-1:0]] = rp_ff[i_ff[IDX_W-1:0]];
               ll_in = ll_ff + LEN_W'(1);
               i_in  = i_ff + LEN_W'(1);
            end
         end
         GS_REPEAT: begin
            if (p_ff == n) begin
               i_in     = '0;
               j_in     = IDX_W'(s_ff);
               rot_in   = '0;
               state_in = GS_ROTATE;
            end else begin
               lp_in[p_ff[IDX_W-1:0]] = lp_ff[i_ff[IDX_W-1:0]];
               p_in = p_ff + LEN_W'(1);
               i_in = i_ff + LEN_W'(1);
            end
         end
         GS_ROTATE: begin
            if (i_ff == n) begin
               state_in = GS_FINISH;
            end else begin
               rot_in[j_ff] = lp_ff[i_ff[IDX_W-1:0]];
               if (LEN_W'(j_ff) + LEN_W'(1) == n) begin
                  j_in = '0;
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
               i_in = i_ff + LEN_W'(1);
            end
         end
         GS_FINISH: begin
            pattern_in = (cfg.invert_pattern ? ~rot_ff : rot_ff) & mask;
            state_in   = GS_IDLE;
         end
         default: begin
            state_in = GS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= GS_IDLE;
         pattern_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pattern_ff <= pattern_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      lp_ff   <= lp_in;
      rp_ff   <= rp_in;
      remp_ff <= remp_in;
      rot_ff  <= rot_in;
      lb_ff   <= lb_in;
      rb_ff   <= rb_in;
      ll_ff   <= ll_in;
      rl_ff   <= rl_in;
      remb_ff <= remb_in;
      reml_ff <= reml_in;
      i_ff    <= i_in;
      p_ff    <= p_in;
      j_ff    <= j_in;
   end

   assign done    = (state_ff == GS_FINISH);
   assign pattern = pattern_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == GS_IDLE)
      else $error("generator started while busy");
   a_copy_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GS_COPY && i_ff != rl_ff) |-> ll_ff < n)
      else $error("block merge writes beyond the cycle length");
   a_repeat_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GS_REPEAT && p_ff != n) |-> i_ff < p_ff)
      else $error("repeat source not behind destination");
   a_pattern_masked: assert property (@(posedge clock) disable iff (reset)
      done |=> (pattern_ff & ~mask) == '0)
      else $error("pattern has bits beyond the cycle length");
`endif

endmodule
`default_nettype wire

// File: design/euclidean_rhythm_sequencer.sv
`default_nettype none
// Euclidean rhythm step sequencer. Each request is one rhythm clock edge; it moves
// the position one step forward (or back when reverse_step is set), forces it to
// zero when sync_reset is set, and returns the beat bit at the new position.
// With an up-to-date pattern an accepted request goes straight to the step state,
// which registers the response once the response output is not stalled and then
// returns to idle for the next request. The first request after reset or any
// register write first rebuilds the pattern in a bit-serial generator: rotation
// reduction, block merging and repetition (both skipped when there are no hits or
// hits fill the length) and rotation, before the step itself. The block takes a
// single request at a time; write registers only while it is idle.
module euclidean_rhythm_sequencer #(
   parameter int MAX_STEPS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_reverse_step,
   input  wire logic                             req_sync_reset,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_beat,
   output logic [ers_pkg::POS_W-1:0]             rsp_step_position,
   input  wire logic                             csr_write_enable,
   input  wire logic [ers_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ers_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ers_pkg::*;

   localparam int LEN_W = $clog2(MAX_STEPS + 1);
   localparam int IDX_W = $clog2(MAX_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_GEN  = 3'b010,
      ST_STEP = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic                 stale_ff, stale_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 beat_ff, beat_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 rev_ff, rev_in;
   logic                 sync_ff, sync_in;
   logic [LENGTH_W-1:0]  length_ff;
   logic [HITS_W-1:0]    hits_ff;
   logic [ROT_W-1:0]     rot_ff;
   logic                 invert_ff;

   cfg_type              cfg;
   logic                 accept;
   logic                 out_free;
   logic                 gen_start;
   logic                 gen_done;
   logic [MAX_STEPS-1:0] pattern;
   logic [LEN_W-1:0]     n;
   logic [IDX_W-1:0]     cur_idx;
   logic [IDX_W-1:0]     next_idx;

   assign cfg.pattern_length = length_ff;
   assign cfg.hit_count      = hits_ff;
   assign cfg.rotation       = rot_ff;
   assign cfg.invert_pattern = invert_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign gen_start = accept && stale_ff;

   ers_gen #(
      .MAX_STEPS (MAX_STEPS)
   ) u_gen (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .start   (gen_start),
      .done    (gen_done),
      .pattern (pattern)
   );

   always_comb begin
      n = LEN_W'(used_length(length_ff, MAX_STEPS));
      if (LEN_W'(idx_ff) >= n) begin
         cur_idx = '0;
      end else begin
         cur_idx = idx_ff;
      end
      if (sync_ff) begin
         next_idx = '0;
      end else if (rev_ff) begin
         if (cur_idx == '0) begin
            next_idx = IDX_W'(n - LEN_W'(1));
         end else begin
            next_idx = cur_idx - IDX_W'(1);
         end
      end else if (LEN_W'(cur_idx) + LEN_W'(1) >= n) begin
         next_idx = '0;
      end else begin
         next_idx = cur_idx + IDX_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      stale_in     = stale_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      beat_in      = beat_ff;
      pos_in       = pos_ff;
      rev_in       = rev_ff;
      sync_in      = sync_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rev_in   = req_reverse_step;
               sync_in  = req_sync_reset;
               state_in = stale_ff ? ST_GEN : ST_STEP;
            end
         end
         ST_GEN: begin
            if (gen_done) begin
               stale_in = 1'b0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (out_free) begin
               idx_in       = next_idx;
               rsp_valid_in = 1'b1;
               beat_in      = pattern[next_idx];
               pos_in       = POS_W'(next_idx);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_write_enable) begin
         stale_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stale_ff     <= 1'b1;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stale_ff     <= stale_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
      pos_ff  <= pos_in;
      rev_ff  <= rev_in;
      sync_ff <= sync_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_RST;
         hits_ff   <= HITS_RST;
         rot_ff    <= ROT_RST;
         invert_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LENGTH:   length_ff <= csr_wdata[LENGTH_W-1:0];
            CSR_HITS:     hits_ff   <= csr_wdata[HITS_W-1:0];
            CSR_ROTATION: rot_ff    <= csr_wdata[ROT_W-1:0];
            CSR_INVERT:   invert_ff <= csr_wdata[0];
            default:      length_ff <= length_ff;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_beat          = beat_ff;
   assign rsp_step_position = pos_ff;

`ifndef SYNTHESIS
   a_done_in_gen: assert property (@(posedge clock) disable iff (reset)
      gen_done |-> state_ff == ST_GEN)
      else $error("generator finished outside regeneration");
   a_stale_regen: assert property (@(posedge clock) disable iff (reset)
      (accept && stale_ff) |=> state_ff == ST_GEN)
      else $error("stale pattern used without regeneration");
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_STEP))
      else $error("response raised outside the step state");
`endif

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
   import ers_pkg::*;

   localparam int          MAX_STEPS   = 32;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SEGMENTS    = 32;

   typedef struct packed {
      logic             beat;
      logic [POS_W-1:0] position;
   } beat_result_type;

   class beat_tracker_type;
      logic [LENGTH_W-1:0] length_reg;
      logic [HITS_W-1:0]   hits_reg;
      logic [ROT_W-1:0]    rotation_reg;
      logic                invert_reg;
      logic [63:0]         pattern;
      logic                stale;
      int unsigned         position;
      beat_result_type     pending_beats[$];
      int unsigned         mismatch_count;

      function new();
         length_reg     = LENGTH_RST;
         hits_reg       = HITS_RST;
         rotation_reg   = ROT_RST;
         invert_reg     = 1'b0;
         pattern        = '0;
         stale          = 1'b1;
         position       = 0;
         mismatch_count = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LENGTH:   length_reg   = data[LENGTH_W-1:0];
            CSR_HITS:     hits_reg     = data[HITS_W-1:0];
            CSR_ROTATION: rotation_reg = data[ROT_W-1:0];
            CSR_INVERT:   invert_reg   = data[0];
         endcase
         stale = 1'b1;
      endfunction

      function int unsigned active_length();
         if (length_reg == 0) return 1;
         if (int'(length_reg) > MAX_STEPS) return MAX_STEPS;
         return length_reg;
      endfunction

      function logic [63:0] low_mask(int unsigned n);
         return (64'd1 << n) - 64'd1;
      endfunction

      // merge left and right blocks until the right side is used up, then repeat the result
      function logic [63:0] spread_hits(int unsigned k, int unsigned n);
         logic [63:0] lp, rp, rem_p;
         int unsigned lb, ll, rb, rl, rem_b, rem_l;
         if (k == 0) return '0;
         if (k >= n) return low_mask(n);
         lp = 64'd1;
         rp = '0;
         lb = k;
         ll = 1;
         rl = 1;
         rb = n - k;
         while (rb != 0) begin
            if (lb > rb) begin
               rem_b = lb - rb;
               rem_p = lp;
               rem_l = ll;
               lb    = rb;
            end else begin
               rem_b = rb - lb;
               rem_p = rp;
               rem_l = rl;
            end
            for (int unsigned i = 0; i < rl; i++) begin
               lp[ll] = rp[i];
               ll++;
            end
            rb = rem_b;
            rp = rem_p;
            rl = rem_l;
         end
         for (int unsigned i = 1; i < lb; i++) begin
            for (int unsigned j = 0; j < ll; j++) begin
               lp[ll * i + j] = lp[j];
            end
         end
         return lp & low_mask(n);
      endfunction

      function void rebuild_pattern();
         int unsigned n, k, s;
         logic [63:0] base, rotated;
         n = active_length();
         k = (hits_reg > n) ? n : hits_reg;
         s = rotation_reg % n;
         base = spread_hits(k, n);
         rotated = '0;
         for (int unsigned i = 0; i < n; i++) begin
            rotated[(i + s) % n] = base[i];
         end
         if (invert_reg) rotated = ~rotated;
         pattern = rotated & low_mask(n);
         if (position >= n) position = 0;
         stale = 1'b0;
      endfunction

      function void note_request(logic rev, logic sync);
         int unsigned n;
         beat_result_type r;
         if (stale) rebuild_pattern();
         n = active_length();
         if (position >= n) position = 0;
         if (rev) begin
            position = (position == 0) ? n - 1 : position - 1;
         end else begin
            position++;
            if (position >= n) position = 0;
         end
         if (sync) position = 0;
         r.beat     = pattern[position];
         r.position = POS_W'(position);
         pending_beats.push_back(r);
      endfunction

      function void report(string msg);
         if (mismatch_count < 10) $display("mismatch: %s", msg);
         mismatch_count++;
      endfunction

      function void check_beat(logic beat, logic [POS_W-1:0] pos);
         beat_result_type want;
         if (pending_beats.size() == 0) begin
            report($sformatf("unexpected response beat=%0b position=%0d", beat, pos));
            return;
         end
         want = pending_beats.pop_front();
         if (beat !== want.beat)
            report($sformatf("beat expected %0b got %0b", want.beat, beat));
         if (pos !== want.position)
            report($sformatf("position expected %0d got %0d", want.position, pos));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_reverse_step = 1'b0;
   logic                  req_sync_reset = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_beat;
   logic [POS_W-1:0]      rsp_step_position;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;

   beat_tracker_type tracker = new();

   euclidean_rhythm_sequencer #(
      .MAX_STEPS(MAX_STEPS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_reverse_step (req_reverse_step),
      .req_sync_reset   (req_sync_reset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_beat         (rsp_beat),
      .rsp_step_position(rsp_step_position),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_request(req_reverse_step, req_sync_reset);
         if (rsp_valid && !rsp_stall) tracker.check_beat(rsp_beat, rsp_step_position);
      end
   end

   task automatic send_step(logic rev, logic sync);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_reverse_step <= rev;
      req_sync_reset   <= sync;
      do @(posedge clock); while (req_stall);
   endtask

   // drop the request line and wait until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      tracker.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic apply_config(logic [3:0] which, logic [CSR_DATA_W-1:0] len,
                               logic [CSR_DATA_W-1:0] hits, logic [CSR_DATA_W-1:0] rot,
                               logic [CSR_DATA_W-1:0] inv);
      settle();
      if (which[CSR_LENGTH])   write_reg(CSR_LENGTH, len);
      if (which[CSR_HITS])     write_reg(CSR_HITS, hits);
      if (which[CSR_ROTATION]) write_reg(CSR_ROTATION, rot);
      if (which[CSR_INVERT])   write_reg(CSR_INVERT, inv);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] len_v, hits_v, rot_v, inv_v;
      logic [3:0]            which;
      int unsigned           count, rev_pct, sync_pct;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset pattern: forward, reverse across zero, sync both ways
      repeat (3) send_step(1'b0, 1'b0);
      repeat (4) send_step(1'b1, 1'b0);
      send_step(1'b0, 1'b1);
      send_step(1'b1, 1'b1);
      // length zero, hits and rotation beyond it, inverted
      apply_config(4'b1111, 6'd0, 6'd63, 6'd63, 6'd1);
      send_step(1'b0, 1'b0);
      send_step(1'b1, 1'b0);
      // length above the maximum, rotation with its unused bit set
      apply_config(4'b1111, 6'd63, 6'd5, 6'd33, 6'd0);
      repeat (6) send_step(1'b0, 1'b0);
      // shrink below the current position, no hits, inverted
      apply_config(4'b1011, 6'd3, 6'd0, 6'd0, 6'd1);
      repeat (2) send_step(1'b0, 1'b0);
      apply_config(4'b1111, 6'd32, 6'd32, 6'd31, 6'd0);
      repeat (2) send_step(1'b1, 1'b0);
      apply_config(4'b0111, 6'd33, 6'd33, 6'd0, 6'd0);
      send_step(1'b0, 1'b1);
      send_step(1'b1, 1'b0);

      for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
         case ($urandom_range(4))
            0: len_v = 6'd0;
            1: len_v = 6'd1;
            2: len_v = 6'd33;
            3: len_v = 6'd63;
            default: len_v = CSR_DATA_W'($urandom_range(1, 32));
         endcase
         case ($urandom_range(5))
            0: hits_v = 6'd0;
            1: hits_v = 6'd63;
            2: hits_v = len_v;
            3: hits_v = len_v + 6'd1;
            default: hits_v = CSR_DATA_W'($urandom_range(0, 33));
         endcase
         rot_v = CSR_DATA_W'($urandom_range(0, 63));
         inv_v = CSR_DATA_W'($urandom_range(0, 63));
         which = (seg == 0) ? 4'b1111 : 4'($urandom_range(0, 15));
         apply_config(which, len_v, hits_v, rot_v, inv_v);

         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         rev_pct  = $urandom_range(0, 100);
         sync_pct = $urandom_range(0, 15);
         count    = $urandom_range(45, 77);
         repeat (count) begin
            send_step($urandom_range(99) < rev_pct, $urandom_range(99) < sync_pct);
         end
      end

      settle();
      if (tracker.mismatch_count == 0 && tracker.pending_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
design/ers_pkg.sv
design/ers_gen.sv
design/euclidean_rhythm_sequencer.sv
bench/tb_top.sv
